// ----- sv/sdds_pkg.sv -----
// shared constants for the sine dds pwm sample unit
`default_nettype none

package sdds_pkg;

    localparam int ACC_W          = 26;
    localparam int VOLUME_W       = 12;
    localparam int SAMPLE_W       = 16;
    localparam int COMPARE_W      = 12;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 16;
    localparam int PRODUCT_W      = SAMPLE_W + VOLUME_W + 1;
    localparam int PRODUCT_SHIFT  = 17;
    localparam int MIDPOINT       = 1200;
    localparam int FULL_SCALE     = 32767;

    localparam int TABLE_LENGTH_DEFAULT  = 1000;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam logic [ACC_W-1:0] STEP_RESET = ACC_W'(440);

endpackage

`default_nettype wire

// ----- sv/sdds_phase.sv -----
// phase accumulator and table address stage
`default_nettype none

module sdds_phase #(
    parameter int TABLE_LENGTH  = sdds_pkg::TABLE_LENGTH_DEFAULT,
    parameter int FRACTION_BITS = sdds_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [sdds_pkg::ACC_W-1:0]       cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [sdds_pkg::VOLUME_W-1:0]    in_volume,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [$clog2(TABLE_LENGTH)-1:0]       out_addr,
    output logic                                  out_in_range,
    output logic [sdds_pkg::VOLUME_W-1:0]         out_volume
);

    localparam int ACC_W  = sdds_pkg::ACC_W;
    localparam int IDX_W  = ACC_W - FRACTION_BITS;
    localparam int ADDR_W = $clog2(TABLE_LENGTH);

    localparam logic [IDX_W:0]   SUM_LIMIT = (IDX_W + 1)'(TABLE_LENGTH);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(TABLE_LENGTH);
    localparam logic [ACC_W:0]   WRAP      = (ACC_W + 1)'(TABLE_LENGTH) << FRACTION_BITS;

    logic [ACC_W-1:0]          step_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          acc_next;
    logic [ACC_W:0]            sum;
    logic [ACC_W:0]            sum_adj;
    logic [IDX_W-1:0]          idx_next;
    logic                      valid_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      in_range_reg;
    logic [sdds_pkg::VOLUME_W-1:0] volume_reg;
    logic                      accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // one table length comes off when the integer part reaches it
    always_comb begin
        sum = {1'b0, acc_reg} + {1'b0, step_reg};
        if (sum[ACC_W:FRACTION_BITS] >= SUM_LIMIT) begin
            sum_adj = sum - WRAP;
        end else begin
            sum_adj = sum;
        end
        acc_next = sum_adj[ACC_W-1:0];
        idx_next = acc_next[ACC_W-1:FRACTION_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= sdds_pkg::STEP_RESET;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (accept) begin
                acc_reg <= acc_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg     <= idx_next[ADDR_W-1:0];
            in_range_reg <= idx_next < IDX_LIMIT;
            volume_reg   <= in_volume;
        end
    end

    assign out_valid    = valid_reg;
    assign out_addr     = addr_reg;
    assign out_in_range = in_range_reg;
    assign out_volume   = volume_reg;

endmodule

`default_nettype wire

// ----- sv/sdds_rom.sv -----
// sine table with registered read
`default_nettype none

module sdds_rom #(
    parameter int TABLE_LENGTH = sdds_pkg::TABLE_LENGTH_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [$clog2(TABLE_LENGTH)-1:0]      in_addr,
    input  wire logic                                 in_in_range,
    input  wire logic [sdds_pkg::VOLUME_W-1:0]        in_volume,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [sdds_pkg::SAMPLE_W-1:0]      out_sample,
    output logic [sdds_pkg::VOLUME_W-1:0]             out_volume
);

    localparam int ADDR_W     = $clog2(TABLE_LENGTH);
    localparam int ROM_DEPTH  = 1 << ADDR_W;
    localparam real HALF_PI   = 1.57079632679489661923;
    localparam real PHASE_UNIT = HALF_PI / real'(TABLE_LENGTH);

    typedef logic signed [sdds_pkg::SAMPLE_W-1:0] rom_t [ROM_DEPTH];

    // floor(32767 * sin(pi/2 * m / length)) for m in [0, length]
    function automatic int quarter_sine(int m);
        real x;
        begin
            x = PHASE_UNIT * real'(m);
            if (m <= 0) begin
                quarter_sine = 0;
            end else if (m >= TABLE_LENGTH) begin
                quarter_sine = sdds_pkg::FULL_SCALE;
            end else begin
                quarter_sine = $rtoi($floor(real'(sdds_pkg::FULL_SCALE) * $sin(x)));
            end
        end
    endfunction

    // full cycle built from one quadrant, rounding toward zero
    function automatic rom_t build_rom();
        rom_t r;
        int   quad;
        int   rem;
        int   v;
        begin
            quad = 0;
            rem  = 0;
            for (int i = 0; i < ROM_DEPTH; i++) begin
                if (i >= TABLE_LENGTH) begin
                    v = 0;
                end else if (quad == 0) begin
                    v = quarter_sine(rem);
                end else if (quad == 1) begin
                    v = quarter_sine(TABLE_LENGTH - rem);
                end else if (quad == 2) begin
                    v = -quarter_sine(rem);
                end else begin
                    v = -quarter_sine(TABLE_LENGTH - rem);
                end
                r[i] = sdds_pkg::SAMPLE_W'(v);
                // quadrant position moves four slots per entry
                rem = rem + 4;
                if (rem >= TABLE_LENGTH) begin
                    rem  = rem - TABLE_LENGTH;
                    quad = quad + 1;
                end
            end
            build_rom = r;
        end
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic                                  valid_reg;
    logic signed [sdds_pkg::SAMPLE_W-1:0]  rom_q_reg;
    logic                                  in_range_reg;
    logic [sdds_pkg::VOLUME_W-1:0]         volume_reg;
    logic                                  advance;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rom_q_reg    <= SINE_ROM[in_addr];
            in_range_reg <= in_in_range;
            volume_reg   <= in_volume;
        end
    end

    // an index past the table reads as zero
    assign out_sample = in_range_reg ? rom_q_reg : '0;
    assign out_valid  = valid_reg;
    assign out_volume = volume_reg;

endmodule

`default_nettype wire

// ----- sv/sdds_scale.sv -----
// volume multiply, shift and midpoint offset into the output register
`default_nettype none

module sdds_scale (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [sdds_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic [sdds_pkg::VOLUME_W-1:0]        in_volume,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [sdds_pkg::COMPARE_W-1:0]            out_compare
);

    localparam int PRODUCT_W = sdds_pkg::PRODUCT_W;

    logic                          prod_valid_reg;
    logic signed [PRODUCT_W-1:0]   product_reg;
    logic signed [PRODUCT_W-1:0]   product_next;
    logic                          prod_ready;
    logic                          out_valid_reg;
    logic [sdds_pkg::COMPARE_W-1:0] compare_reg;
    logic signed [PRODUCT_W-1:0]   scaled;

    assign out_valid  = out_valid_reg;
    assign out_compare = compare_reg;

    assign prod_ready = !out_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;

    assign product_next = PRODUCT_W'(in_sample) *
                          $signed({1'b0, in_volume});

    // arithmetic shift floors negative products
    assign scaled = (product_reg >>> sdds_pkg::PRODUCT_SHIFT) +
                    PRODUCT_W'(sdds_pkg::MIDPOINT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            product_reg <= product_next;
        end
        if (prod_valid_reg && prod_ready) begin
            compare_reg <= scaled[sdds_pkg::COMPARE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- sv/sine_dds_pwm_sample_unit.sv -----
// sine dds pwm sample unit: phase accumulator, sine table, volume scaling
// an input transfer passes the phase, table, product and compare registers on its way to m_tvalid
// throughput: one transfer per cycle unless the output stalls, each pipeline stage with its own valid
// a stalled output backs up stage by stage; bubbles still fill while it waits
// reset (aresetn low, synchronous) empties the pipeline, zeroes the phase
// accumulator and loads the phase step with 440
`default_nettype none

module sine_dds_pwm_sample_unit #(
    parameter int TABLE_LENGTH  = sdds_pkg::TABLE_LENGTH_DEFAULT,
    parameter int FRACTION_BITS = sdds_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sdds_pkg::ACC_W-1:0]         cfg_wr_data,   // phase_step
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [sdds_pkg::S_TDATA_W-1:0]     s_tdata,       // [11:0] volume_level
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [sdds_pkg::M_TDATA_W-1:0]          m_tdata        // [11:0] compare_value
);

    localparam int ADDR_W = $clog2(TABLE_LENGTH);

    logic                                  ph_valid;
    logic                                  ph_ready;
    logic [ADDR_W-1:0]                     ph_addr;
    logic                                  ph_in_range;
    logic [sdds_pkg::VOLUME_W-1:0]         ph_volume;
    logic                                  rom_valid;
    logic                                  rom_ready;
    logic signed [sdds_pkg::SAMPLE_W-1:0]  rom_sample;
    logic [sdds_pkg::VOLUME_W-1:0]         rom_volume;
    logic [sdds_pkg::COMPARE_W-1:0]        compare_value;

    sdds_phase #(
        .TABLE_LENGTH  (TABLE_LENGTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_phase (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_volume    (s_tdata[sdds_pkg::VOLUME_W-1:0]),
        .out_valid    (ph_valid),
        .out_ready    (ph_ready),
        .out_addr     (ph_addr),
        .out_in_range (ph_in_range),
        .out_volume   (ph_volume)
    );

    sdds_rom #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_rom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (ph_valid),
        .in_ready    (ph_ready),
        .in_addr     (ph_addr),
        .in_in_range (ph_in_range),
        .in_volume   (ph_volume),
        .out_valid   (rom_valid),
        .out_ready   (rom_ready),
        .out_sample  (rom_sample),
        .out_volume  (rom_volume)
    );

    sdds_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (rom_valid),
        .in_ready    (rom_ready),
        .in_sample   (rom_sample),
        .in_volume   (rom_volume),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_compare (compare_value)
    );

    assign m_tdata = {{(sdds_pkg::M_TDATA_W - sdds_pkg::COMPARE_W){1'b0}}, compare_value};

endmodule

`default_nettype wire

// ----- sv/sdds_checker.sv -----
// port-level checks for the sine dds pwm sample unit, bound to the top level
`default_nettype none

module sdds_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [sdds_pkg::M_TDATA_W-1:0] m_tdata
);

    // every result lies in the scaled sine range or is the midpoint
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= sdds_pkg::M_TDATA_W'(176)) &&
                     (m_tdata <= sdds_pkg::M_TDATA_W'(2223)))
        else $error("compare value out of range");

    // a held result keeps its value until the transfer
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input only stalls when the whole pipeline is full behind a stalled output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sine_dds_pwm_sample_unit sdds_checker u_sdds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- verif/tb_sine_dds_pwm_sample_unit.sv -----
// self-checking testbench for the sine dds pwm sample unit
`default_nettype none

module tb_sine_dds_pwm_sample_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W         = sdds_pkg::ACC_W;
    localparam int VOLUME_W      = sdds_pkg::VOLUME_W;
    localparam int SAMPLE_W      = sdds_pkg::SAMPLE_W;
    localparam int COMPARE_W     = sdds_pkg::COMPARE_W;
    localparam int S_TDATA_W     = sdds_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = sdds_pkg::M_TDATA_W;
    localparam int PRODUCT_SHIFT = sdds_pkg::PRODUCT_SHIFT;
    localparam int MIDPOINT      = sdds_pkg::MIDPOINT;
    localparam int FULL_SCALE    = sdds_pkg::FULL_SCALE;

    localparam int TABLE_LEN   = sdds_pkg::TABLE_LENGTH_DEFAULT;
    localparam int FRAC_BITS   = sdds_pkg::FRACTION_BITS_DEFAULT;
    localparam int SERIES_TERMS = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1846;
    localparam logic [ACC_W-1:0] STEP_TOP_IN_RANGE = ACC_W'((TABLE_LEN << FRAC_BITS) - 1);
    localparam logic [ACC_W-1:0] STEP_ALL_ONES     = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [ACC_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [11:0] volume_level
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [11:0] compare_value

    // predictor state
    logic signed [SAMPLE_W-1:0] sine_table [TABLE_LEN];
    logic [ACC_W-1:0]           phase_step;
    logic [ACC_W-1:0]           phase_acc;
    logic [COMPARE_W-1:0]       expected_compare [$];

    int mismatches;
    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int quiet_cycles;

    sine_dds_pwm_sample_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // floor(a*b / 2^60) over the full product
    function automatic longint unsigned q60_mul(input longint unsigned a, input longint unsigned b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // floor(32767 * sin(pi/2 * m / TABLE_LEN)) by a truncated taylor series in q60
    function automatic int quarter_wave(input int unsigned m);
        longint unsigned x, x2, term, total;
        if (m == 0) return 0;
        if (m >= TABLE_LEN) return FULL_SCALE;
        x = (HALF_PI_Q60 / TABLE_LEN) * m + ((HALF_PI_Q60 % TABLE_LEN) * m) / TABLE_LEN;
        x2 = q60_mul(x, x);
        term = x;
        total = x;
        for (int unsigned k = 1; k <= SERIES_TERMS; k++) begin
            term = q60_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
            if (k[0]) total = total - term;
            else total = total + term;
        end
        return int'(q60_mul(total, FULL_SCALE));
    endfunction

    task automatic build_sine_table();
        int unsigned quad, rem;
        int v;
        for (int unsigned i = 0; i < TABLE_LEN; i++) begin
            quad = (4 * i) / TABLE_LEN;
            rem = (4 * i) % TABLE_LEN;
            case (quad)
                0: v = quarter_wave(rem);
                1: v = quarter_wave(TABLE_LEN - rem);
                2: v = -quarter_wave(rem);
                default: v = -quarter_wave(TABLE_LEN - rem);
            endcase
            sine_table[i] = SAMPLE_W'(v);
        end
    endtask

    // advance the phase by one tick and form the compare value
    function automatic logic [COMPARE_W-1:0] next_compare(input logic [VOLUME_W-1:0] volume);
        logic [ACC_W:0] total;
        int unsigned idx;
        int sample, prod, scaled;
        total = {1'b0, phase_acc} + {1'b0, phase_step};
        if ((total >> FRAC_BITS) >= TABLE_LEN)
            total = total - ((ACC_W + 1)'(TABLE_LEN) << FRAC_BITS);
        phase_acc = total[ACC_W-1:0];
        idx = int'(phase_acc >> FRAC_BITS);
        // integer part past the table reads as silence
        sample = (idx < TABLE_LEN) ? int'(sine_table[idx]) : 0;
        prod = sample * int'(volume);
        scaled = prod >>> PRODUCT_SHIFT;
        return COMPARE_W'(scaled + MIDPOINT);
    endfunction

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_compare.size() == 0) begin
                $error("compare_value: unexpected transfer, actual %0d", m_tdata[COMPARE_W-1:0]);
                mismatches++;
            end else begin
                logic [COMPARE_W-1:0] want;
                want = expected_compare.pop_front();
                if (m_tdata[COMPARE_W-1:0] !== want) begin
                    $error("compare_value: expected %0d actual %0d", want,
                        m_tdata[COMPARE_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sine_dds_pwm_sample_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic [VOLUME_W-1:0] volume);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{(S_TDATA_W - VOLUME_W){1'b0}}, volume};
        do @(posedge aclk); while (!s_tready);
        expected_compare.push_back(next_compare(volume));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_compare.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic load_phase_step(input logic [ACC_W-1:0] value);
        drain_results();
        cfg_wr_data = value;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        phase_step = value;
    endtask

    function automatic logic [VOLUME_W-1:0] random_volume();
        if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
        return VOLUME_W'($urandom_range(4095));
    endfunction

    function automatic logic [ACC_W-1:0] random_step();
        case ($urandom_range(3))
            0: return ACC_W'($urandom_range(1 << 18));
            1: return ACC_W'($urandom_range(int'(STEP_ALL_ONES), int'(STEP_TOP_IN_RANGE) + 1));
            default: return ACC_W'($urandom_range(int'(STEP_TOP_IN_RANGE)));
        endcase
    endfunction

    // step after reset, volume extremes and alternating bit patterns
    task automatic test_reset_step();
        send_tick(12'h000);
        send_tick(12'hFFF);
        send_tick(12'h001);
        send_tick(12'h800);
        send_tick(12'hAAA);
        send_tick(12'h555);
    endtask

    // quarter-cycle step lands on the positive and negative peaks
    task automatic test_peak_swing();
        load_phase_step(ACC_W'(TABLE_LEN / 4) << FRAC_BITS);
        repeat (4) send_tick(12'hFFF);
        send_tick(12'h000);
        send_tick(12'hFFF);
    endtask

    // park the phase at the top of the table, then an oversized step runs past it
    task automatic test_past_table();
        logic [ACC_W:0] gap;
        gap = {1'b0, STEP_TOP_IN_RANGE} + (ACC_W + 1)'(TABLE_LEN << FRAC_BITS)
            - {1'b0, phase_acc};
        if (gap >= (ACC_W + 1)'(TABLE_LEN << FRAC_BITS))
            gap = gap - (ACC_W + 1)'(TABLE_LEN << FRAC_BITS);
        load_phase_step(gap[ACC_W-1:0]);
        send_tick(12'hFFF);
        load_phase_step(STEP_ALL_ONES);
        send_tick(12'hFFF);
        send_tick(12'hFFF);
        send_tick(12'h7FF);
        load_phase_step(STEP_TOP_IN_RANGE);
        send_tick(12'hFFF);
        send_tick(12'hFFF);
    endtask

    task automatic test_zero_step();
        load_phase_step('0);
        send_tick(12'hFFF);
        send_tick(12'h123);
    endtask

    task automatic test_random_phases();
        int idle_modes [4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{19, 19}};
        for (int mode = 0; mode < 4; mode++) begin
            for (int part = 0; part < 2; part++) begin
                load_phase_step(random_step());
                send_idle_pct = idle_modes[mode][0];
                stall_pct = idle_modes[mode][1];
                repeat (75) send_tick(random_volume());
                send_idle_pct = 0;
                stall_pct = 0;
            end
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        load_phase_step(random_step());
        hold_left = 80;
        repeat (40) send_tick(random_volume());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        mismatches = 0;
        quiet_cycles = 0;
        build_sine_table();
        phase_step = sdds_pkg::STEP_RESET;
        phase_acc = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_step();
        test_peak_swing();
        test_past_table();
        test_zero_step();
        test_random_phases();
        test_backpressure();
        drain_results();

        if (mismatches == 0)
            $display("sine_dds_pwm_sample_unit regression: pass");
        else
            $display("sine_dds_pwm_sample_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
